// ===== design/eabf_pkg.sv =====
// Shared constants and types for the edge-aware 3x3 box mean filter.
`timescale 1ns / 1ps

package eabf_pkg;

    localparam int MAX_COLS_DEF  = 1024;
    localparam int FRAC_BITS_DEF = 8;

    localparam int SAMPLE_W      = 8;
    localparam int NUM_COLS_W    = 11;
    localparam int NUM_COLS_RST  = 256;
    localparam int MEAN_W        = 16;
    localparam int OUT_COL_W     = 10;
    localparam int CSUM_W        = 10;    // one column of up to three bytes
    localparam int SUM_W         = 12;    // up to nine bytes
    localparam int PADDR_W       = 2;
    localparam int PDATA_W       = 32;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [PADDR_W-1:0] ADDR_NUM_COLS = '0;

    // Window summary handed from the front end to the mean unit, one per item
    // that yields at least one result.
    typedef struct packed {
        logic              has_first;   // result for the previous column
        logic              has_left;    // that result has a left neighbor
        logic              is_last;     // result for the current (last) column
        logic [1:0]        vert;        // rows that count: 1 to 3
        logic [CSUM_W-1:0] sum_cur;
        logic [CSUM_W-1:0] sum_w0;
        logic [CSUM_W-1:0] sum_w1;
    } win_info_t;

    localparam int WIN_INFO_W = $bits(win_info_t);

endpackage

// ===== design/edge_aware_box3x3_mean_filter.sv =====
// Top level of the edge-aware 3x3 box mean filter with its register port.
`timescale 1ns / 1ps

// Streams a heightmap in raster order, one 8-bit sample per beat, and returns
// for every position the mean of its in-bounds 3x3 neighborhood (divide by 9
// inside, 6 on an edge, 4 in a corner) as unsigned fixed point with FRAC_BITS
// fraction bits, rounded to nearest with halves up. Results trail the input
// by one row and one column: an input beat at column c >= 1 yields the mean
// for column c-1 of the row above, and the beat at the last column yields a
// second result for that column, flagged end_of_row; last_of_run marks the
// final result of each input beat. Mark the first beat of a map with
// frame_start, and after the last row send num_cols drain beats to flush it.
// Throughput is one beat per clock sustained while m_ready stays high: the
// front end reads both line buffers once per beat and the mean unit issues
// one result per clock, so the extra result at the end of a row is balanced
// by the first column, which yields none. A four-entry queue between them
// absorbs that and short stalls on m_ready; s_ready drops only when that
// queue, counting the beat still held in the front end, is full. An accepted
// beat's first result passes the front-end stage, the queue and the b0, b1
// and output registers. Line buffers need no clearing after reset. Write
// num_cols (register 0, byte address 0) only while the filter is idle;
// values outside 2..MAX_COLS are clamped.
module edge_aware_box3x3_mean_filter
    import eabf_pkg::*;
#(
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    // sample stream in
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_sample,
    input  logic                  s_drain,
    input  logic                  s_frame_start,
    // means out
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [MEAN_W-1:0]     m_mean_q8,
    output logic [OUT_COL_W-1:0]  m_out_col,
    output logic                  m_end_of_row,
    output logic                  m_last_of_run
);

    localparam int CW       = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int COLS_RST = (NUM_COLS_RST > MAX_COLS) ? MAX_COLS : NUM_COLS_RST;
    localparam logic [CW-1:0] LAST_RST = CW'(COLS_RST - 1);

    logic [NUM_COLS_W-1:0] num_cols_reg;
    logic [CW-1:0]         last_col_reg, last_col_next;
    logic                  cfg_wr;
    int                    cols_clamped;

    logic                  in_fire, f1_busy, push, pop, q_empty;
    logic [CW-1:0]         push_col, q_col;
    win_info_t             push_info, q_info;
    logic [CNT_W-1:0]      q_count;

    // Register port: keep the raw value for readback, the clamped last
    // column for the datapath.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_NUM_COLS);
    assign prdata = (paddr == ADDR_NUM_COLS) ? PDATA_W'(num_cols_reg) : '0;

    always_comb begin
        cols_clamped = int'(pwdata[NUM_COLS_W-1:0]);
        if (cols_clamped < 2) begin
            cols_clamped = 2;
        end else if (cols_clamped > MAX_COLS) begin
            cols_clamped = MAX_COLS;
        end
        last_col_next = CW'(cols_clamped - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg <= NUM_COLS_W'(NUM_COLS_RST);
            last_col_reg <= LAST_RST;
        end else if (cfg_wr) begin
            num_cols_reg <= pwdata[NUM_COLS_W-1:0];
            last_col_reg <= last_col_next;
        end
    end

    // Take a beat only when the queue can hold it and the one still in
    // the front end.
    assign s_ready = (int'(q_count) + int'(f1_busy)) < QUEUE_DEPTH;
    assign in_fire = s_valid && s_ready;

    eabf_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .sample      (s_sample),
        .drain       (s_drain),
        .frame_start (s_frame_start),
        .last_col    (last_col_reg),
        .f1_busy     (f1_busy),
        .push        (push),
        .push_col    (push_col),
        .push_info   (push_info)
    );

    eabf_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (CW + WIN_INFO_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_col, push_info}),
        .pop       (pop),
        .pop_data  ({q_col, q_info}),
        .empty     (q_empty),
        .count     (q_count)
    );

    eabf_back #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (!q_empty),
        .q_col         (q_col),
        .q_info        (q_info),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mean_q8     (m_mean_q8),
        .m_out_col     (m_out_col),
        .m_end_of_row  (m_end_of_row),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// ===== design/eabf_front.sv =====
// Front end: column/row tracking, line buffers and the 3x3 window summary.
`timescale 1ns / 1ps

module eabf_front
    import eabf_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    localparam int CW = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                drain,
    input  logic                frame_start,
    input  logic [CW-1:0]       last_col,
    output logic                f1_busy,
    output logic                push,
    output logic [CW-1:0]       push_col,
    output win_info_t           push_info
);

    localparam int TW = 3 * SAMPLE_W;

    logic [SAMPLE_W-1:0] upper_mem  [MAX_COLS];
    logic [SAMPLE_W-1:0] middle_mem [MAX_COLS];

    logic [CW-1:0]       col_count_reg, col_count_next;
    logic [1:0]          row_phase_reg, row_phase_next;
    logic                f1_valid_reg;
    logic [CW-1:0]       f1_col_reg;
    logic [SAMPLE_W-1:0] f1_bot_reg;
    logic                f1_drain_reg;
    logic [1:0]          f1_phase_reg;
    logic                f1_last_reg;
    logic [SAMPLE_W-1:0] rd_up_reg, rd_mid_reg;
    logic                byp_reg;
    logic [SAMPLE_W-1:0] byp_up_reg, byp_mid_reg;
    logic [TW-1:0]       w0_reg, w1_reg;

    logic [CW-1:0]       col_eff, col_sel;
    logic [1:0]          phase_eff;
    logic                at_last;
    logic [SAMPLE_W-1:0] up_eff, mid_eff;
    logic [TW-1:0]       cur;
    logic                top_ok, bot_ok;

    function automatic logic [CSUM_W-1:0] column_sum(
        input logic [TW-1:0] triple,
        input logic          top,
        input logic          bot
    );
        logic [CSUM_W-1:0] s;
        s = CSUM_W'(triple[2*SAMPLE_W-1:SAMPLE_W]);
        if (top) s = s + CSUM_W'(triple[TW-1:2*SAMPLE_W]);
        if (bot) s = s + CSUM_W'(triple[SAMPLE_W-1:0]);
        return s;
    endfunction

    // Accept side: pick the column and advance position state.
    always_comb begin
        col_eff   = frame_start ? '0 : col_count_reg;
        phase_eff = frame_start ? 2'd0 : row_phase_reg;
        col_sel   = (col_eff > last_col) ? last_col : col_eff;
        at_last   = (col_sel == last_col);
        col_count_next = col_count_reg;
        row_phase_next = row_phase_reg;
        if (in_fire) begin
            if (at_last) begin
                col_count_next = '0;
                if (drain) begin
                    row_phase_next = 2'd0;
                end else if (phase_eff != 2'd2) begin
                    row_phase_next = phase_eff + 2'd1;
                end else begin
                    row_phase_next = phase_eff;
                end
            end else begin
                col_count_next = col_sel + CW'(1);
                row_phase_next = phase_eff;
            end
        end
    end

    // Second stage: line data arrives; take the previous item's write if it
    // hit the same column.
    always_comb begin
        up_eff  = byp_reg ? byp_up_reg  : rd_up_reg;
        mid_eff = byp_reg ? byp_mid_reg : rd_mid_reg;
        cur     = {up_eff, mid_eff, f1_bot_reg};
        top_ok  = (f1_phase_reg == 2'd2);
        bot_ok  = !f1_drain_reg;

        push_info.has_first = (f1_col_reg != '0);
        push_info.has_left  = (f1_col_reg > CW'(1));
        push_info.is_last   = f1_last_reg;
        push_info.vert      = 2'd1 + 2'(top_ok) + 2'(bot_ok);
        push_info.sum_cur   = column_sum(cur, top_ok, bot_ok);
        push_info.sum_w0    = column_sum(w0_reg, top_ok, bot_ok);
        push_info.sum_w1    = column_sum(w1_reg, top_ok, bot_ok);

        push     = f1_valid_reg && (f1_phase_reg != 2'd0)
                   && (push_info.has_first || push_info.is_last);
        push_col = f1_col_reg;
        f1_busy  = f1_valid_reg;
    end

    // Line buffers: read on accept, shift the column down from the second stage.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            rd_up_reg  <= upper_mem[col_sel];
            rd_mid_reg <= middle_mem[col_sel];
        end
        if (f1_valid_reg) begin
            upper_mem[f1_col_reg]  <= mid_eff;
            middle_mem[f1_col_reg] <= f1_bot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            f1_col_reg   <= col_sel;
            f1_bot_reg   <= drain ? '0 : sample;
            f1_drain_reg <= drain;
            f1_phase_reg <= phase_eff;
            f1_last_reg  <= at_last;
            byp_reg      <= f1_valid_reg && (f1_col_reg == col_sel);
            byp_up_reg   <= mid_eff;
            byp_mid_reg  <= f1_bot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_phase_reg <= 2'd0;
            f1_valid_reg  <= 1'b0;
            w0_reg        <= '0;
            w1_reg        <= '0;
        end else begin
            col_count_reg <= col_count_next;
            row_phase_reg <= row_phase_next;
            f1_valid_reg  <= in_fire;
            if (f1_valid_reg) begin
                w1_reg <= w0_reg;
                w0_reg <= cur;
            end
        end
    end

endmodule

// ===== design/eabf_fifo.sv =====
// Small queue that decouples the window front end from the mean unit.
`timescale 1ns / 1ps

module eabf_fifo
    import eabf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH,
    parameter int WIDTH = WIN_INFO_W,
    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic [CNT_W-1:0] count
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign pop_data = entry_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < CNT_W'(DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");

endmodule

// ===== design/eabf_back.sv =====
// Mean unit: turns window summaries into rounded fixed-point means.
`timescale 1ns / 1ps

module eabf_back
    import eabf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int CW = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  logic [CW-1:0]        q_col,
    input  win_info_t            q_info,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [MEAN_W-1:0]    m_mean_q8,
    output logic [OUT_COL_W-1:0] m_out_col,
    output logic                 m_end_of_row,
    output logic                 m_last_of_run
);

    localparam int NUM_W = SUM_W + FRAC_BITS;
    localparam logic [NUM_W-1:0] RECIP_2 = NUM_W'((64'd1 << NUM_W) / 2);
    localparam logic [NUM_W-1:0] RECIP_3 = NUM_W'((64'd1 << NUM_W) / 3);
    localparam logic [NUM_W-1:0] RECIP_4 = NUM_W'((64'd1 << NUM_W) / 4);
    localparam logic [NUM_W-1:0] RECIP_6 = NUM_W'((64'd1 << NUM_W) / 6);
    localparam logic [NUM_W-1:0] RECIP_9 = NUM_W'((64'd1 << NUM_W) / 9);

    logic                 second_reg, second_next;

    logic                 b0_valid_reg;
    logic [NUM_W-1:0]     b0_num_reg, b0_recip_reg;
    logic [3:0]           b0_div_reg;
    logic [CW-1:0]        b0_col_reg;
    logic                 b0_eor_reg, b0_lor_reg;

    logic                 b1_valid_reg;
    logic [2*NUM_W-1:0]   b1_prod_reg;
    logic [NUM_W-1:0]     b1_num_reg;
    logic [3:0]           b1_div_reg;
    logic [CW-1:0]        b1_col_reg;
    logic                 b1_eor_reg, b1_lor_reg;

    logic                 out_valid_reg;
    logic [MEAN_W-1:0]    out_mean_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic                 out_eor_reg, out_lor_reg;

    logic                 out_ready, b1_ready, b0_ready, issue, first_sel;
    logic [CSUM_W-1:0]    center, left, right;
    logic [1:0]           horiz;
    logic [SUM_W-1:0]     sum;
    logic [3:0]           div;
    logic [NUM_W-1:0]     num, recip;
    logic [CW-1:0]        sel_col;
    logic                 sel_eor, sel_lor;
    logic [NUM_W-1:0]     q0, qd, rem, qr;
    logic [MEAN_W-1:0]    mean;

    assign out_ready = !out_valid_reg || m_ready;
    assign b1_ready  = !b1_valid_reg || out_ready;
    assign b0_ready  = !b0_valid_reg || b1_ready;
    assign issue     = q_valid && b0_ready;
    assign first_sel = q_info.has_first && !second_reg;

    // Issue: pick which of the entry's results goes next and build the
    // rounded numerator.
    always_comb begin
        if (first_sel) begin
            center  = q_info.sum_w0;
            left    = q_info.has_left ? q_info.sum_w1 : '0;
            right   = q_info.sum_cur;
            horiz   = q_info.has_left ? 2'd3 : 2'd2;
            sel_col = q_col - CW'(1);
            sel_eor = 1'b0;
            sel_lor = !q_info.is_last;
        end else begin
            center  = q_info.sum_cur;
            left    = q_info.sum_w0;
            right   = '0;
            horiz   = 2'd2;
            sel_col = q_col;
            sel_eor = 1'b1;
            sel_lor = 1'b1;
        end
        sum = SUM_W'(center) + SUM_W'(left) + SUM_W'(right);
        div = 4'(q_info.vert) * 4'(horiz);
        num = (NUM_W'(sum) << FRAC_BITS) + NUM_W'(div >> 1);
        unique case (div)
            4'd2:    recip = RECIP_2;
            4'd3:    recip = RECIP_3;
            4'd4:    recip = RECIP_4;
            4'd6:    recip = RECIP_6;
            4'd9:    recip = RECIP_9;
            default: recip = '0;
        endcase
        q_pop       = issue && sel_lor;
        second_next = issue ? (first_sel && q_info.is_last) : second_reg;
    end

    // Finish: the reciprocal estimate is low by at most one.
    always_comb begin
        q0   = b1_prod_reg[2*NUM_W-1:NUM_W];
        qd   = NUM_W'(q0 * NUM_W'(b1_div_reg));
        rem  = b1_num_reg - qd;
        qr   = q0 + NUM_W'(rem >= NUM_W'(b1_div_reg));
        mean = (int'(qr) > 65535) ? '1 : MEAN_W'(qr);
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            b0_num_reg   <= num;
            b0_recip_reg <= recip;
            b0_div_reg   <= div;
            b0_col_reg   <= sel_col;
            b0_eor_reg   <= sel_eor;
            b0_lor_reg   <= sel_lor;
        end
        if (b0_valid_reg && b1_ready) begin
            b1_prod_reg <= b0_num_reg * b0_recip_reg;
            b1_num_reg  <= b0_num_reg;
            b1_div_reg  <= b0_div_reg;
            b1_col_reg  <= b0_col_reg;
            b1_eor_reg  <= b0_eor_reg;
            b1_lor_reg  <= b0_lor_reg;
        end
        if (b1_valid_reg && out_ready) begin
            out_mean_reg <= mean;
            out_col_reg  <= OUT_COL_W'(b1_col_reg);
            out_eor_reg  <= b1_eor_reg;
            out_lor_reg  <= b1_lor_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_reg    <= 1'b0;
            b0_valid_reg  <= 1'b0;
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            second_reg <= second_next;
            if (b0_ready)  b0_valid_reg  <= issue;
            if (b1_ready)  b1_valid_reg  <= b0_valid_reg;
            if (out_ready) out_valid_reg <= b1_valid_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_mean_q8     = out_mean_reg;
    assign m_out_col     = out_col_reg;
    assign m_end_of_row  = out_eor_reg;
    assign m_last_of_run = out_lor_reg;

    a_eor_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_eor_reg) |-> out_lor_reg)
        else $error("end-of-row result not marked last of run");

    a_second_holds_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        second_reg |-> q_valid)
        else $error("pending second result lost its queue entry");

endmodule

// ===== test/edge_aware_box3x3_mean_filter_tb.sv =====
// Self-checking testbench for the edge-aware 3x3 box mean filter.
`timescale 1ns / 1ps

module edge_aware_box3x3_mean_filter_tb;
    import eabf_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 3;
    // Clocks to hold off after the last mean before touching num_cols; this
    // leaves a wide margin for a beat still inside the block.
    localparam int QUIET_CYCLES  = 12;
    localparam int STALL_LIMIT   = 1000;
    localparam int IDLE_PCT      = 8;
    localparam int RANDOM_BEATS  = 960;
    localparam int SMALL_PHASES  = 8;
    localparam int BIG_COLS      = 64;
    localparam int BIG_STRETCH   = 48;
    localparam int MAX_ERR_LINES = 50;
    localparam int N_DIRECTED    = 25;
    localparam int N_PHASES      = 10;
    localparam int CALM_PHASE    = 4;
    localparam logic [MEAN_W-1:0] FULL_MEAN = 16'hFF00;

    typedef enum logic {CHECK_PREDICT, CHECK_TYPED} check_kind_e;

    // How many map rows lie above the row now being streamed.
    typedef enum logic [1:0] {ABOVE_NONE, ABOVE_ONE, ABOVE_TWO} rows_above_e;

    typedef struct packed {
        logic [MEAN_W-1:0]    mean_q8;
        logic [OUT_COL_W-1:0] out_col;
        logic                 end_of_row;
        logic                 last_of_run;
    } mean_beat_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                drain;
        logic                frame_start;
        check_kind_e         kind;
        logic [1:0]          n_typed;
        mean_beat_t          first;
        mean_beat_t          second;
    } dir_row_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value.
    // ------------------------------------------------------------------
    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]   pwdata        = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [SAMPLE_W-1:0]  s_sample      = '0;
    logic                 s_drain       = 1'b0;
    logic                 s_frame_start = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [MEAN_W-1:0]    m_mean_q8;
    logic [OUT_COL_W-1:0] m_out_col;
    logic                 m_end_of_row;
    logic                 m_last_of_run;

    always #HALF_PERIOD aclk = ~aclk;

    edge_aware_box3x3_mean_filter DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_drain       (s_drain),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mean_q8     (m_mean_q8),
        .m_out_col     (m_out_col),
        .m_end_of_row  (m_end_of_row),
        .m_last_of_run (m_last_of_run)
    );

    // ------------------------------------------------------------------
    // Shadow of the filter: line buffers, window columns, position and the
    // programmed row length, advanced once per accepted input beat.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0]   upper_row  [MAX_COLS_DEF];
    logic [SAMPLE_W-1:0]   middle_row [MAX_COLS_DEF];
    logic [23:0]           win_prev   = '0;
    logic [23:0]           win_prev2  = '0;
    int unsigned           cur_col    = 0;
    rows_above_e           rows_above = ABOVE_NONE;
    logic [NUM_COLS_W-1:0] num_cols_reg = NUM_COLS_W'(NUM_COLS_RST);

    mean_beat_t  pending_means [$];   // means still owed by the block, oldest first
    int unsigned beats_in      = 0;
    int unsigned means_out     = 0;
    int unsigned settings_seen = 0;
    int unsigned err_count     = 0;
    int unsigned stall_cycles  = 0;
    bit          calm          = 1'b0; // no idling on either side while set

    int unsigned phase_cols [N_PHASES] = '{5, 1, 3, 0, 12, 2047, 2, 33, 1024, 6};

    task automatic report_mismatch(input string what);
        if (err_count < MAX_ERR_LINES) begin
            $display("MISMATCH @%0t: %s", $time, what);
        end
        err_count++;
    endtask

    function automatic int unsigned clamp_cols(input int unsigned raw);
        if (raw < 2) return 2;
        if (raw > MAX_COLS_DEF) return MAX_COLS_DEF;
        return raw;
    endfunction

    // Sum one vertical triple {top, middle, bottom}; middle always counts.
    function automatic int unsigned column_total(input logic [23:0] stack,
                                                 input bit top_ok, input bit bot_ok);
        int unsigned s;
        s = 32'(stack[15:8]);
        if (top_ok) s += 32'(stack[23:16]);
        if (bot_ok) s += 32'(stack[7:0]);
        return s;
    endfunction

    function automatic logic [MEAN_W-1:0] box_mean(
        input logic [23:0] ctr, input logic [23:0] lft, input bit has_l,
        input logic [23:0] rgt, input bit has_r, input bit top_ok, input bit bot_ok);
        int unsigned total, across, rows, cnt, q;
        total  = column_total(ctr, top_ok, bot_ok);
        across = 1;
        rows   = 1 + (top_ok ? 1 : 0) + (bot_ok ? 1 : 0);
        if (has_l) begin
            total += column_total(lft, top_ok, bot_ok);
            across++;
        end
        if (has_r) begin
            total += column_total(rgt, top_ok, bot_ok);
            across++;
        end
        cnt = rows * across;
        // Round to nearest, halves up, then clip to the output width.
        q = ((total << FRAC_BITS_DEF) + cnt / 2) / cnt;
        if (q > 32'hFFFF) q = 32'hFFFF;
        return q[MEAN_W-1:0];
    endfunction

    // Advance the shadow by one input beat; queue its means when asked to.
    task automatic filter_step(input logic [SAMPLE_W-1:0] smp, input logic drn,
                               input logic fs, input bit keep);
        int unsigned cols, last, c;
        logic [23:0] cur;
        bit          top_ok, bot_ok;
        mean_beat_t  made [2];
        int          n;
        n = 0;
        if (fs) begin
            cur_col    = 0;
            rows_above = ABOVE_NONE;
        end
        cols = clamp_cols(num_cols_reg);
        last = cols - 1;
        // A position past a shortened row is taken as the last column.
        c      = (cur_col > last) ? last : cur_col;
        cur    = {upper_row[c], middle_row[c], drn ? 8'd0 : smp};
        top_ok = (rows_above == ABOVE_TWO);
        bot_ok = !drn;
        if (rows_above != ABOVE_NONE) begin
            if (c >= 1) begin
                made[n].mean_q8     = box_mean(win_prev, win_prev2, c >= 2, cur, 1'b1,
                                               top_ok, bot_ok);
                made[n].out_col     = OUT_COL_W'(c - 1);
                made[n].end_of_row  = 1'b0;
                made[n].last_of_run = 1'b0;
                n++;
            end
            if (c == last) begin
                made[n].mean_q8     = box_mean(cur, win_prev, 1'b1, 24'd0, 1'b0,
                                               top_ok, bot_ok);
                made[n].out_col     = OUT_COL_W'(c);
                made[n].end_of_row  = 1'b1;
                made[n].last_of_run = 1'b0;
                n++;
            end
            if (n > 0) made[n-1].last_of_run = 1'b1;
        end
        if (keep) begin
            for (int k = 0; k < n; k++) pending_means.push_back(made[k]);
        end
        upper_row[c]  = middle_row[c];
        middle_row[c] = drn ? 8'd0 : smp;
        win_prev2     = win_prev;
        win_prev      = cur;
        if (c == last) begin
            cur_col = 0;
            if (drn) rows_above = ABOVE_NONE;
            else if (rows_above == ABOVE_NONE) rows_above = ABOVE_ONE;
            else rows_above = ABOVE_TWO;
        end else begin
            cur_col = c + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: present one beat, hold it until s_ready takes it, then
    // advance the shadow. Now and then drop valid and idle first.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [SAMPLE_W-1:0] smp, input logic drn,
                             input logic fs, input bit keep);
        int unsigned gap;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            gap = $urandom_range(3, 1);
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_sample      <= smp;
        s_drain       <= drn;
        s_frame_start <= fs;
        do @(posedge aclk); while (!s_ready);
        filter_step(smp, drn, fs, keep);
        beats_in++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Register port: setup clock, then access clock until pready.
    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Program the row length and read it back; clamped values are only
    // checked through the means they produce.
    task automatic set_columns(input int unsigned raw);
        logic [PDATA_W-1:0] rd;
        reg_write(ADDR_NUM_COLS, PDATA_W'(raw));
        num_cols_reg = NUM_COLS_W'(raw);
        reg_read(ADDR_NUM_COLS, rd);
        if (raw >= 2 && raw <= MAX_COLS_DEF && rd !== PDATA_W'(raw)) begin
            report_mismatch($sformatf("num_cols read back %0d, wrote %0d", rd, raw));
        end
        settings_seen++;
    endtask

    // Drop valid, wait until every owed mean is in, then hold off a while
    // longer in case a result-free beat is still in flight.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // One map: frame_start, rows of samples, then a drain row. Small maps get
    // the odd drain hole inside a row and the odd restart of the frame.
    task automatic run_map(input int unsigned cols, input int unsigned rows);
        int unsigned roll;
        bit          noisy;
        noisy = (cols <= BIG_COLS);
        send_beat(pick_sample(), 1'b0, 1'b1, 1'b1);
        for (int unsigned i = 1; i < rows * cols; i++) begin
            roll = noisy ? $urandom_range(99) : 99;
            if (roll < 3) send_beat(pick_sample(), 1'b1, 1'b0, 1'b1);
            else if (roll == 3) send_beat(pick_sample(), 1'b0, 1'b1, 1'b1);
            else send_beat(pick_sample(), 1'b0, 1'b0, 1'b1);
        end
        for (int unsigned i = 0; i < cols; i++) begin
            send_beat(pick_sample(), 1'b1, 1'b0, 1'b1);
        end
    endtask

    task automatic run_phase(input int unsigned raw);
        int unsigned cols, start, rows, budget;
        settle();
        set_columns(raw);
        cols   = clamp_cols(raw);
        budget = RANDOM_BEATS / SMALL_PHASES;
        // Row shortened under a parked column: the next beat lands on the
        // new last column; follow it with a row so the effect shows up.
        if (cur_col > cols - 1) begin
            send_beat(pick_sample(), 1'b0, 1'b0, 1'b1);
            repeat (cols) send_beat(pick_sample(), 1'b0, 1'b0, 1'b1);
        end
        if (cols > BIG_COLS) begin
            // Long rows: stream only the start of row 0 and park far out, so
            // the next, shorter row length lands on its last column.
            send_beat(pick_sample(), 1'b0, 1'b1, 1'b1);
            repeat (BIG_STRETCH - 1) send_beat(pick_sample(), 1'b0, 1'b0, 1'b1);
        end else begin
            start = beats_in;
            do begin
                rows = $urandom_range(6, 1);
                run_map(cols, rows);
                // Stray drains between maps, some flagged as a frame start.
                repeat ($urandom_range(2)) begin
                    send_beat(pick_sample(), 1'b1, ($urandom_range(3) == 0), 1'b1);
                end
            end while (beats_in - start < budget);
        end
        // Flush whatever map a restart left open, then park mid-row.
        while (rows_above != ABOVE_NONE) send_beat(pick_sample(), 1'b1, 1'b0, 1'b1);
        repeat ($urandom_range(4, 2)) send_beat(pick_sample(), 1'b1, 1'b0, 1'b1);
    endtask

    function automatic mean_beat_t mb(input logic [MEAN_W-1:0] m, input int unsigned col,
                                      input logic eor, input logic lst);
        mb.mean_q8     = m;
        mb.out_col     = OUT_COL_W'(col);
        mb.end_of_row  = eor;
        mb.last_of_run = lst;
    endfunction

    function automatic dir_row_t typed_row(input logic [SAMPLE_W-1:0] smp, input logic drn,
                                           input logic fs, input int unsigned n,
                                           input mean_beat_t a, input mean_beat_t b);
        typed_row.sample      = smp;
        typed_row.drain       = drn;
        typed_row.frame_start = fs;
        typed_row.kind        = CHECK_TYPED;
        typed_row.n_typed     = 2'(n);
        typed_row.first       = a;
        typed_row.second      = b;
    endfunction

    function automatic dir_row_t free_row(input logic [SAMPLE_W-1:0] smp, input logic drn,
                                          input logic fs);
        free_row      = typed_row(smp, drn, fs, 0, '0, '0);
        free_row.kind = CHECK_PREDICT;
    endfunction

    // ------------------------------------------------------------------
    // Output side: check every accepted mean against the oldest owed one,
    // and stall m_ready at random.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : mean_monitor
        mean_beat_t got, want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_mean_q8, m_out_col, m_end_of_row, m_last_of_run};
                means_out++;
                if (pending_means.size() == 0) begin
                    report_mismatch($sformatf("unexpected mean %h col %0d", got.mean_q8,
                                              got.out_col));
                end else begin
                    want = pending_means.pop_front();
                    if (got !== want) begin
                        report_mismatch($sformatf(
                            "got mean=%h col=%0d eor=%b last=%b, want mean=%h col=%0d eor=%b last=%b",
                            got.mean_q8, got.out_col, got.end_of_row, got.last_of_run,
                            want.mean_q8, want.out_col, want.end_of_row, want.last_of_run));
                    end
                end
            end
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: give up when neither channel moves a beat for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("No beat moved for %0d cycles, %0d means still owed",
                         STALL_LIMIT, pending_means.size());
                $display("RESULT: ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, register checks, directed table, random phases.
    // ------------------------------------------------------------------
    initial begin : stimulus
        dir_row_t           dir_tab [N_DIRECTED];
        dir_row_t           row;
        logic [PDATA_W-1:0] rd;
        mean_beat_t         full_a, full_b, zero_a, zero_b;

        full_a = mb(FULL_MEAN, 0, 1'b0, 1'b0);
        full_b = mb(FULL_MEAN, 1, 1'b1, 1'b1);
        zero_a = mb('0, 0, 1'b0, 1'b0);
        zero_b = mb('0, 1, 1'b1, 1'b1);

        // Two-column maps. All-ones map: every mean is full scale, whatever
        // the divisor. Drain beats carry junk samples that must be ignored.
        dir_tab[0]  = typed_row(8'hFF, 1'b0, 1'b1, 0, '0, '0);
        dir_tab[1]  = typed_row(8'hFF, 1'b0, 1'b0, 0, '0, '0);
        dir_tab[2]  = typed_row(8'hFF, 1'b0, 1'b0, 0, '0, '0);
        dir_tab[3]  = typed_row(8'hFF, 1'b0, 1'b0, 2, full_a, full_b);
        dir_tab[4]  = typed_row(8'hFF, 1'b0, 1'b0, 0, '0, '0);
        dir_tab[5]  = typed_row(8'hFF, 1'b0, 1'b0, 2, full_a, full_b);
        dir_tab[6]  = typed_row(8'h00, 1'b1, 1'b0, 0, '0, '0);
        dir_tab[7]  = typed_row(8'hFF, 1'b1, 1'b0, 2, full_a, full_b);
        // Drains while idle, one with frame_start: nothing comes out.
        dir_tab[8]  = typed_row(8'hA5, 1'b1, 1'b0, 0, '0, '0);
        dir_tab[9]  = typed_row(8'h5A, 1'b1, 1'b0, 0, '0, '0);
        dir_tab[10] = typed_row(8'h00, 1'b1, 1'b1, 0, '0, '0);
        // All-zero map.
        dir_tab[11] = typed_row(8'h00, 1'b0, 1'b1, 0, '0, '0);
        dir_tab[12] = typed_row(8'h00, 1'b0, 1'b0, 0, '0, '0);
        dir_tab[13] = typed_row(8'h00, 1'b0, 1'b0, 0, '0, '0);
        dir_tab[14] = typed_row(8'h00, 1'b0, 1'b0, 2, zero_a, zero_b);
        // Restart mid-map, a drain hole in row 1, a drain on the last beat of row 2.
        dir_tab[15] = free_row(8'd3,   1'b0, 1'b1);
        dir_tab[16] = free_row(8'd250, 1'b0, 1'b0);
        dir_tab[17] = free_row(8'd77,  1'b1, 1'b0);
        dir_tab[18] = free_row(8'd128, 1'b0, 1'b0);
        dir_tab[19] = free_row(8'd9,   1'b0, 1'b0);
        dir_tab[20] = free_row(8'd1,   1'b1, 1'b0);
        // Single-row map: horizontal averaging only, odd sum rounds.
        dir_tab[21] = free_row(8'd1,   1'b0, 1'b1);
        dir_tab[22] = free_row(8'd254, 1'b0, 1'b0);
        dir_tab[23] = free_row(8'd0,   1'b1, 1'b0);
        dir_tab[24] = free_row(8'd0,   1'b1, 1'b0);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        reg_read(ADDR_NUM_COLS, rd);
        if (rd !== PDATA_W'(NUM_COLS_RST)) begin
            report_mismatch($sformatf("num_cols after reset %0d, want %0d", rd, NUM_COLS_RST));
        end
        set_columns(2);

        // Walk the table; typed rows owe exactly the means written in them.
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = dir_tab[i];
            send_beat(row.sample, row.drain, row.frame_start, row.kind == CHECK_PREDICT);
            if (row.kind == CHECK_TYPED) begin
                if (row.n_typed >= 1) pending_means.push_back(row.first);
                if (row.n_typed >= 2) pending_means.push_back(row.second);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            calm = (p == CALM_PHASE);
            run_phase(phase_cols[p]);
        end
        calm = 1'b0;

        settle();
        $display("Streamed %0d input beats and checked %0d means across %0d row lengths,",
                 beats_in, means_out, settings_seen);
        $display("including clamped lengths, restarts, drain holes and stalls on both sides.");
        if (err_count == 0 && pending_means.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
